### rtl/core/gfcu_pkg.sv
// Shared constants for the gyro frame check and heading unwrap block.
// Byte offsets of the checked frame fields, checksum seeds and turn thresholds.
// No dependencies.
package gfcu_pkg;

  // Widths of the stream payload
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 2;

  // Only these burst positions are ever read, so only these are held
  localparam int TAPS = 8;

  localparam int TAP_RATE_LO = 0;
  localparam int TAP_RATE_HI = 1;
  localparam int TAP_RATE_CK = 2;
  localparam int TAP_HDG_LO  = 3;
  localparam int TAP_HDG_HI  = 4;
  localparam int TAP_HDG_X0  = 5;
  localparam int TAP_HDG_X1  = 6;
  localparam int TAP_HDG_CK  = 7;

  localparam int TAP_POS [TAPS] = '{6, 7, 10, 17, 18, 19, 20, 21};

  localparam logic [7:0] RATE_SEED    = 8'hA7;
  localparam logic [7:0] HEADING_SEED = 8'hA8;

  // 270 and 90 degrees in units of 180/32768 degree
  localparam logic [15:0] RAW_AT_270 = 16'd49152;
  localparam logic [15:0] RAW_AT_90  = 16'd16384;

  localparam logic signed [15:0] TURNS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TURNS_MIN = 16'sh8000;

  typedef logic [7:0] byte_t;

endpackage

### rtl/core/gyro_frame_check_and_unwrap.sv
// Gyro serial frame check and heading unwrap, top level.
// A burst_end request's result appears on out_* from the result register in the cycle after acceptance.
// Throughput: one request per cycle while the result slot is free or being taken; set by the single result register.
// Data bytes are taken even while a result waits, burst_end waits for the result slot.
// Reset (rst_n low, synchronous) clears the held bytes, write position, held words,
// turn count and the result valid flag. Depends on gfcu_pkg.
module gyro_frame_check_and_unwrap
  import gfcu_pkg::*;
#(
  parameter int STORE_BYTES = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream: one received byte or an idle marker per request
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] burst_end
  // Result stream: one result per idle marker
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] rate_raw, [31:16] heading_raw,
                                            // [47:32] turn_count, [79:48] unwrapped_heading
  output logic [OUT_USER_W-1:0] out_tuser   // [0] rate_fresh, [1] heading_fresh
);

  // Write position must be able to hold STORE_BYTES itself (saturation point)
  localparam int PW = $clog2(STORE_BYTES + 1);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic is_idle;
  logic byte_fire;
  logic idle_fire;

  assign is_idle   = in_tuser[0];
  // A data byte never produces a result, so it need not wait for the result slot
  assign in_tready = !out_tvalid || out_tready || !is_idle;
  assign in_fire   = in_tvalid && in_tready;
  assign byte_fire = in_fire && !is_idle;
  assign idle_fire = in_fire && is_idle;

  // ---------------------------------------------------------------------------
  // Burst store: write position and the bytes at the checked offsets.
  // Positions outside the taps are counted but never read, so not held.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] wr_pos_r, wr_pos_nxt;
  byte_t         tap_r [TAPS];
  logic          store_open;

  assign store_open = wr_pos_r < PW'(STORE_BYTES);

  always_comb begin
    wr_pos_nxt = wr_pos_r;
    if (idle_fire) begin
      wr_pos_nxt = '0;
    end else if (byte_fire && store_open) begin
      wr_pos_nxt = wr_pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
    end else begin
      wr_pos_r <= wr_pos_nxt;
    end
  end

  for (genvar g = 0; g < TAPS; g++) begin : g_tap
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tap_r[g] <= '0;
      end else if (byte_fire && store_open && wr_pos_r == PW'(TAP_POS[g])) begin
        tap_r[g] <= in_tdata[7:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checksums over the held bytes (8-bit wrap-around sums)
  // ---------------------------------------------------------------------------
  byte_t       rate_sum;
  byte_t       hdg_sum;
  logic        rate_ok;
  logic        hdg_ok;
  logic [15:0] rate_word;
  logic [15:0] hdg_word;

  assign rate_sum  = RATE_SEED + tap_r[TAP_RATE_LO] + tap_r[TAP_RATE_HI];
  assign hdg_sum   = HEADING_SEED + tap_r[TAP_HDG_LO] + tap_r[TAP_HDG_HI]
                   + tap_r[TAP_HDG_X0] + tap_r[TAP_HDG_X1];
  assign rate_ok   = rate_sum == tap_r[TAP_RATE_CK];
  assign hdg_ok    = hdg_sum == tap_r[TAP_HDG_CK];
  assign rate_word = {tap_r[TAP_RATE_HI], tap_r[TAP_RATE_LO]};
  assign hdg_word  = {tap_r[TAP_HDG_HI], tap_r[TAP_HDG_LO]};

  // ---------------------------------------------------------------------------
  // Held words and turn tracking
  // ---------------------------------------------------------------------------
  logic [15:0]        rate_r, rate_nxt;
  logic [15:0]        hdg_r, hdg_nxt;
  logic [15:0]        prev_hdg_r, prev_hdg_nxt;
  logic signed [15:0] turns_r, turns_nxt;
  logic               wrap_up;
  logic               wrap_down;

  // Crossing north: from above 270 degrees to below 90, or the reverse
  assign wrap_up   = (hdg_r > RAW_AT_270) && (hdg_word < RAW_AT_90);
  assign wrap_down = (hdg_r < RAW_AT_90) && (hdg_word > RAW_AT_270);

  always_comb begin
    rate_nxt     = rate_r;
    hdg_nxt      = hdg_r;
    prev_hdg_nxt = prev_hdg_r;
    turns_nxt    = turns_r;
    if (idle_fire && rate_ok) begin
      rate_nxt = rate_word;
    end
    if (idle_fire && hdg_ok) begin
      prev_hdg_nxt = hdg_r;
      hdg_nxt      = hdg_word;
      priority if (wrap_up) begin
        if (turns_r != TURNS_MAX) turns_nxt = turns_r + 16'sd1;
      end else if (wrap_down) begin
        if (turns_r != TURNS_MIN) turns_nxt = turns_r - 16'sd1;
      end else begin
        turns_nxt = turns_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= '0;
      hdg_r      <= '0;
      prev_hdg_r <= '0;
      turns_r    <= '0;
    end else begin
      rate_r     <= rate_nxt;
      hdg_r      <= hdg_nxt;
      prev_hdg_r <= prev_hdg_nxt;
      turns_r    <= turns_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on an idle marker, drop valid once taken
  // ---------------------------------------------------------------------------
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (idle_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset; the previous heading is kept for reference only
  always_ff @(posedge clk) begin
    if (idle_fire) begin
      out_data_r <= {turns_nxt, hdg_nxt, turns_nxt, hdg_nxt, rate_nxt};
      out_user_r <= {hdg_ok, rate_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    idle_fire |=> out_tvalid)
    else $error("idle marker accepted without a result");

  a_pos_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    wr_pos_r <= PW'(STORE_BYTES))
    else $error("write position beyond store");

  a_pos_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (byte_fire && store_open) |=> wr_pos_r == $past(wr_pos_r) + PW'(1))
    else $error("write position did not advance on a stored byte");

  a_turn_step : assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (turns_r == $past(turns_r) || turns_r == $past(turns_r) + 16'sd1
         || turns_r == $past(turns_r) - 16'sd1))
    else $error("turn count moved by more than one");

  a_prev_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    (idle_fire && hdg_ok) |=> prev_hdg_r == $past(hdg_r))
    else $error("previous heading not taken from held heading");

  a_unwrap_consistent : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[79:64] == out_tdata[47:32]
                    && out_tdata[63:48] == out_tdata[31:16]))
    else $error("unwrapped heading disagrees with turn count or heading");

endmodule

### tb/sv/testbench.sv
// Self-checking bench for gyro_frame_check_and_unwrap: byte bursts and idle markers in,
// checked results out, with random idling on both streams.
// Depends on gfcu_pkg and the gyro_frame_check_and_unwrap top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gfcu_pkg::*;

  localparam int STORE_BYTES = 22;

  // Byte offsets of the checked frame fields within a burst
  localparam int RATE_LO_POS = 6;
  localparam int RATE_HI_POS = 7;
  localparam int RATE_CK_POS = 10;
  localparam int HDG_LO_POS  = 17;
  localparam int HDG_HI_POS  = 18;
  localparam int HDG_X0_POS  = 19;
  localparam int HDG_X1_POS  = 20;
  localparam int HDG_CK_POS  = 21;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;

  typedef struct {
    byte_t rx_byte;
    logic  burst_end;
  } rx_request_t;

  typedef struct {
    logic [15:0]        rate_raw;
    logic               rate_fresh;
    logic [15:0]        heading_raw;
    logic               heading_fresh;
    logic signed [15:0] turn_count;
    logic [31:0]        unwrapped_heading;
  } gyro_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] rx_byte
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [0] burst_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [15:0] rate_raw, [31:16] heading_raw,
                                          // [47:32] turn_count, [79:48] unwrapped_heading
  logic [OUT_USER_W-1:0] out_tuser;       // [0] rate_fresh, [1] heading_fresh

  gyro_frame_check_and_unwrap #(
    .STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: burst bytes, write position, held words and turn count
  byte_t              frame_store [STORE_BYTES];
  int                 write_pos;
  logic [15:0]        held_rate;
  logic [15:0]        held_heading;
  logic [15:0]        prior_heading;
  logic signed [15:0] whole_turns;

  rx_request_t  pending_requests [$];
  gyro_result_t awaited_results [$];
  rx_request_t  staged_request;

  int accepted_requests = 0;
  int total_requests = 0;
  int results_checked = 0;
  int rate_fresh_seen = 0;
  int heading_fresh_seen = 0;
  int lowest_turns = 0;
  int highest_turns = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_phase = 0;

  // Fold one accepted request into the shadow; an idle marker queues one result
  task automatic absorb_request(input byte_t rx, input logic idle);
    logic [7:0]   rate_sum;
    logic [7:0]   hdg_sum;
    logic         rate_ok;
    logic         hdg_ok;
    gyro_result_t res;
    if (!idle) begin
      // drop bytes once the store is full
      if (write_pos < STORE_BYTES) begin
        frame_store[write_pos] = rx;
        write_pos++;
      end
    end else begin
      rate_sum = RATE_SEED + frame_store[RATE_LO_POS] + frame_store[RATE_HI_POS];
      rate_ok = (rate_sum == frame_store[RATE_CK_POS]);
      if (rate_ok)
        held_rate = {frame_store[RATE_HI_POS], frame_store[RATE_LO_POS]};
      hdg_sum = HEADING_SEED + frame_store[HDG_LO_POS] + frame_store[HDG_HI_POS]
                + frame_store[HDG_X0_POS] + frame_store[HDG_X1_POS];
      hdg_ok = (hdg_sum == frame_store[HDG_CK_POS]);
      if (hdg_ok) begin
        prior_heading = held_heading;
        held_heading = {frame_store[HDG_HI_POS], frame_store[HDG_LO_POS]};
        if (prior_heading > RAW_AT_270 && held_heading < RAW_AT_90) begin
          if (whole_turns != TURNS_MAX) whole_turns++;
        end else if (prior_heading < RAW_AT_90 && held_heading > RAW_AT_270) begin
          if (whole_turns != TURNS_MIN) whole_turns--;
        end
      end
      write_pos = 0;
      res.rate_raw          = held_rate;
      res.rate_fresh        = rate_ok;
      res.heading_raw       = held_heading;
      res.heading_fresh     = hdg_ok;
      res.turn_count        = whole_turns;
      res.unwrapped_heading = {whole_turns, held_heading};
      awaited_results.push_back(res);
    end
  endtask

  task automatic queue_byte(input byte_t b);
    rx_request_t r;
    r.rx_byte   = b;
    r.burst_end = 1'b0;
    pending_requests.push_back(r);
  endtask

  task automatic queue_idle();
    rx_request_t r;
    r.rx_byte   = byte_t'($urandom_range(255));
    r.burst_end = 1'b1;
    pending_requests.push_back(r);
  endtask

  // Build one frame with random filler, send its first length bytes, then the idle marker
  task automatic queue_frame(input logic [15:0] rate, input bit rate_good,
                             input logic [15:0] heading, input bit heading_good,
                             input int length);
    byte_t frame [STORE_BYTES];
    int    i;
    for (i = 0; i < STORE_BYTES; i++) frame[i] = byte_t'($urandom_range(255));
    frame[RATE_LO_POS] = rate[7:0];
    frame[RATE_HI_POS] = rate[15:8];
    frame[RATE_CK_POS] = RATE_SEED + rate[7:0] + rate[15:8];
    if (!rate_good) frame[RATE_CK_POS] += byte_t'($urandom_range(1, 255));
    frame[HDG_LO_POS] = heading[7:0];
    frame[HDG_HI_POS] = heading[15:8];
    frame[HDG_CK_POS] = HEADING_SEED + heading[7:0] + heading[15:8]
                        + frame[HDG_X0_POS] + frame[HDG_X1_POS];
    if (!heading_good) frame[HDG_CK_POS] += byte_t'($urandom_range(1, 255));
    for (i = 0; i < length; i++)
      queue_byte(i < STORE_BYTES ? frame[i] : byte_t'($urandom_range(255)));
    queue_idle();
  endtask

  // Favour the quadrants either side of north so that turns happen both ways
  function automatic logic [15:0] pick_heading();
    case ($urandom_range(7))
      0, 1, 2: pick_heading = 16'($urandom_range(16383));
      3, 4, 5: pick_heading = 16'($urandom_range(65535, 49153));
      6:       pick_heading = 16'($urandom_range(49152, 16384));
      default: begin
        case ($urandom_range(5))
          0:       pick_heading = 16'd0;
          1:       pick_heading = RAW_AT_90 - 16'd1;
          2:       pick_heading = RAW_AT_90;
          3:       pick_heading = RAW_AT_270;
          4:       pick_heading = RAW_AT_270 + 16'd1;
          default: pick_heading = 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Idle mix by thirds of the run: sender 21 / receiver 68, then swapped, then none
  always @(posedge clk) begin
    if (accepted_requests < total_requests / 3) idle_phase <= 0;
    else if (accepted_requests < 2 * total_requests / 3) idle_phase <= 1;
    else idle_phase <= 2;
  end

  // Driver: predict on acceptance, then hold or advance the request on the input stream
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_request(in_tdata, in_tuser[0]);
        accepted_requests++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99) >= (idle_phase == 0 ? 21 : idle_phase == 1 ? 68 : 0)) begin
          staged_request = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= staged_request.rx_byte;
          in_tuser  <= staged_request.burst_end;
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= IN_DATA_W'($urandom_range(255));
          in_tuser  <= IN_USER_W'($urandom_range(1));
        end
      end
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each accepted result with the oldest expectation, stall at random
  always @(posedge clk) begin
    gyro_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no idle marker outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("rate_raw", want.rate_raw, out_tdata[15:0]);
          check_field("rate_fresh", want.rate_fresh, out_tuser[0]);
          check_field("heading_raw", want.heading_raw, out_tdata[31:16]);
          check_field("heading_fresh", want.heading_fresh, out_tuser[1]);
          check_field("turn_count", {16'h0000, want.turn_count}, out_tdata[47:32]);
          check_field("unwrapped_heading", want.unwrapped_heading, out_tdata[79:48]);
          results_checked++;
          rate_fresh_seen += want.rate_fresh;
          heading_fresh_seen += want.heading_fresh;
          if (want.turn_count < lowest_turns) lowest_turns = want.turn_count;
          if (want.turn_count > highest_turns) highest_turns = want.turn_count;
        end
      end
      out_tready <= ($urandom_range(99) >= (idle_phase == 0 ? 68 : idle_phase == 1 ? 21 : 0));
    end
  end

  // Watchdog: end the run if neither stream moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("gyro_frame_check_and_unwrap: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int kind;
    int n;
    int i;
    write_pos     = 0;
    held_rate     = '0;
    held_heading  = '0;
    prior_heading = '0;
    whole_turns   = '0;
    for (i = 0; i < STORE_BYTES; i++) frame_store[i] = '0;

    // Directed: empty burst on the cleared store, extremes, overflow, short burst,
    // each checksum failing on its own, and re-evaluation of a stale store
    queue_idle();
    queue_frame(16'hFFFF, 1, 16'hFFFF, 1, STORE_BYTES);
    queue_frame(16'h0000, 1, 16'h0000, 1, STORE_BYTES + 4);
    queue_frame(16'h1234, 1, 16'hC001, 1, 12);
    queue_frame(16'h00FF, 0, 16'hFF00, 1, STORE_BYTES);
    queue_frame(16'h8000, 1, 16'h8000, 0, STORE_BYTES);
    queue_idle();
    queue_idle();

    // Random: mostly whole frames, mixed with short, overlong and pure noise bursts
    n = pending_requests.size() + RANDOM_REQUESTS;
    while (pending_requests.size() < n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        queue_frame(16'($urandom_range(65535)), $urandom_range(99) < 85, pick_heading(),
                    $urandom_range(99) < 85, STORE_BYTES);
      end else if (kind < 80) begin
        queue_frame(16'($urandom_range(65535)), $urandom_range(1), pick_heading(),
                    $urandom_range(1), $urandom_range(STORE_BYTES - 1));
      end else if (kind < 88) begin
        queue_frame(16'($urandom_range(65535)), $urandom_range(1), pick_heading(),
                    $urandom_range(1), $urandom_range(STORE_BYTES + 12, STORE_BYTES + 1));
      end else begin
        repeat ($urandom_range(40)) queue_byte(byte_t'($urandom_range(255)));
        queue_idle();
      end
    end
    total_requests = pending_requests.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results; rate frames taken %0d, heading frames %0d",
             accepted_requests, results_checked, rate_fresh_seen, heading_fresh_seen);
    $display("turn count ranged from %0d to %0d", lowest_turns, highest_turns);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("gyro_frame_check_and_unwrap: match");
    else
      $display("gyro_frame_check_and_unwrap: mismatch");
    $finish;
  end

endmodule
